FILE: rtl/cpi_pkg.sv
// Shared types and constants for the circle pair intersection pipeline.
package cpi_pkg;

    // Default centre coordinate width (signed Q4.28 at 32 bits)
    localparam int COORD_WIDTH_DEF = 32;

    // Digit width of the pipelined multipliers: one digit times the full operand per stage
    localparam int DIG_W = 16;

    // Classification of a disk pair
    typedef enum logic [1:0] {
        REL_TWO       = 2'd0,
        REL_CONTAINED = 2'd1,
        REL_DISJOINT  = 2'd2
    } t_relation;

endpackage

FILE: rtl/cpi_if.sv
// Valid/ready channels for disk pair beats and intersection result beats.
interface cpi_pair_if #(
    parameter int W = cpi_pkg::COORD_WIDTH_DEF
);
    logic                valid;
    logic                ready;
    logic signed [W-1:0] first_x;
    logic signed [W-1:0] first_y;
    logic        [W-2:0] first_radius;
    logic signed [W-1:0] other_x;
    logic signed [W-1:0] other_y;
    logic        [W-2:0] other_radius;

    modport source (
        output valid, first_x, first_y, first_radius, other_x, other_y, other_radius,
        input  ready
    );
    modport sink (
        input  valid, first_x, first_y, first_radius, other_x, other_y, other_radius,
        output ready
    );
endinterface

interface cpi_res_if #(
    parameter int W = cpi_pkg::COORD_WIDTH_DEF
);
    logic                valid;
    logic                ready;
    cpi_pkg::t_relation  relation;
    logic signed [W-1:0] point0_x;
    logic signed [W-1:0] point0_y;
    logic signed [W-1:0] point1_x;
    logic signed [W-1:0] point1_y;

    modport source (
        output valid, relation, point0_x, point0_y, point1_x, point1_y,
        input  ready
    );
    modport sink (
        input  valid, relation, point0_x, point0_y, point1_x, point1_y,
        output ready
    );
endinterface

FILE: rtl/cpi_dly.sv
// Enabled delay line that carries valid bits and side data alongside the arithmetic units.
module cpi_dly #(
    parameter int WD    = 8,
    parameter int DEPTH = 4
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_en,
    input  logic [WD-1:0] i_d,
    output logic [WD-1:0] o_q
);
    logic [WD-1:0] r_pipe [DEPTH];

    // Shift on enable; clear so the valid bits start low
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < DEPTH; i++) begin
                r_pipe[i] <= '0;
            end
        end else if (i_en) begin
            r_pipe[0] <= i_d;
            for (int i = 1; i < DEPTH; i++) begin
                r_pipe[i] <= r_pipe[i-1];
            end
        end
    end

    assign o_q = r_pipe[DEPTH-1];
endmodule

FILE: rtl/cpi_mul.sv
// Pipelined unsigned multiplier: one digit of the first operand per stage.
module cpi_mul #(
    parameter int WA = 33,
    parameter int WB = 33
) (
    input  logic             i_clk,
    input  logic             i_en,
    input  logic [WA-1:0]    i_a,
    input  logic [WB-1:0]    i_b,
    output logic [WA+WB-1:0] o_p
);
    import cpi_pkg::*;

    localparam int NS  = (WA + DIG_W - 1) / DIG_W;
    localparam int WAP = NS * DIG_W;
    localparam int WP  = WA + WB;

    logic [WAP-1:0] r_a   [NS];
    logic [WB-1:0]  r_b   [NS];
    logic [WP-1:0]  r_acc [NS];
    logic [WAP-1:0] a_pad;

    assign a_pad = WAP'(i_a);

    for (genvar k = 0; k < NS; k++) begin : g_st
        logic [DIG_W+WB-1:0] pp;
        logic [WAP-1:0]      a_src;
        logic [WB-1:0]       b_src;
        logic [WP-1:0]       acc_src;

        if (k == 0) begin : g_first
            assign a_src   = a_pad;
            assign b_src   = i_b;
            assign acc_src = '0;
        end else begin : g_next
            assign a_src   = r_a[k-1];
            assign b_src   = r_b[k-1];
            assign acc_src = r_acc[k-1];
        end

        // Partial product of this digit
        assign pp = a_src[k*DIG_W +: DIG_W] * b_src;

        // Accumulate the shifted partial product
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_a[k]   <= a_src;
                r_b[k]   <= b_src;
                r_acc[k] <= acc_src + (WP'(pp) << (k * DIG_W));
            end
        end
    end

    assign o_p = r_acc[NS-1];
endmodule

FILE: rtl/cpi_sqrt.sv
// Pipelined floor square root: one root bit per stage.
module cpi_sqrt #(
    parameter int WI = 128
) (
    input  logic            i_clk,
    input  logic            i_en,
    input  logic [WI-1:0]   i_x,
    output logic [WI/2-1:0] o_root
);
    localparam int WR = WI / 2;
    localparam int WM = WR + 2;

    logic [WI-1:0] r_x    [WR];
    logic [WM-1:0] r_rem  [WR];
    logic [WR-1:0] r_root [WR];

    for (genvar j = 0; j < WR; j++) begin : g_st
        logic [WI-1:0] x_src;
        logic [WM-1:0] rem_src;
        logic [WR-1:0] root_src;
        logic [WM-1:0] rem_sh;
        logic [WM-1:0] trial;
        logic          ge;

        if (j == 0) begin : g_first
            assign x_src    = i_x;
            assign rem_src  = '0;
            assign root_src = '0;
        end else begin : g_next
            assign x_src    = r_x[j-1];
            assign rem_src  = r_rem[j-1];
            assign root_src = r_root[j-1];
        end

        // Bring in the next two bits and try root*4+1
        assign rem_sh = {rem_src[WM-3:0], x_src[WI-1-2*j -: 2]};
        assign trial  = {root_src, 2'b01};
        assign ge     = (rem_sh >= trial);

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_x[j]    <= x_src;
                r_rem[j]  <= ge ? (rem_sh - trial) : rem_sh;
                r_root[j] <= {root_src[WR-2:0], ge};
            end
        end
    end

    assign o_root = r_root[WR-1];
endmodule

FILE: rtl/cpi_div.sv
// Pipelined restoring divider: one quotient bit per stage, quotient known to fit QW bits.
module cpi_div #(
    parameter int WN  = 101,
    parameter int WDV = 67,
    parameter int QW  = 33
) (
    input  logic           i_clk,
    input  logic           i_en,
    input  logic [WN-1:0]  i_num,
    input  logic [WDV-1:0] i_den,
    output logic [QW-1:0]  o_quo
);
    localparam int WR = WN - QW;

    logic [WN-1:0]  r_n   [QW];
    logic [WDV-1:0] r_d   [QW];
    logic [WR-1:0]  r_rem [QW];
    logic [QW-1:0]  r_q   [QW];

    for (genvar j = 0; j < QW; j++) begin : g_st
        logic [WN-1:0]  n_src;
        logic [WDV-1:0] d_src;
        logic [WR-1:0]  rem_src;
        logic [QW-1:0]  q_src;
        logic [WR:0]    cand;
        logic [WR:0]    d_ext;
        logic           ge;

        if (j == 0) begin : g_first
            assign n_src   = i_num;
            assign d_src   = i_den;
            assign rem_src = i_num[WN-1 -: WR];
            assign q_src   = '0;
        end else begin : g_next
            assign n_src   = r_n[j-1];
            assign d_src   = r_d[j-1];
            assign rem_src = r_rem[j-1];
            assign q_src   = r_q[j-1];
        end

        // Shift in the next numerator bit and subtract when it fits
        assign cand  = {rem_src, n_src[QW-1-j]};
        assign d_ext = (WR+1)'(d_src);
        assign ge    = (cand >= d_ext);

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_n[j]   <= n_src;
                r_d[j]   <= d_src;
                r_rem[j] <= WR'(ge ? (cand - d_ext) : cand);
                r_q[j]   <= {q_src[QW-2:0], ge};
            end
        end
    end

    assign o_quo = r_q[QW-1];
endmodule

FILE: rtl/circle_pair_intersection.sv
// Circle pair intersection: fully pipelined classifier and crossing point solver.
//
// Takes one disk pair beat per clock while the output is not stalled and returns one result
// beat per pair, in order. The digit-serial multipliers are M = ceil((COORD_WIDTH+1)/16) and
// K = ceil(2*COORD_WIDTH/16) stages deep; the square root is one bit per stage (2*COORD_WIDTH
// stages) and the divider one bit per stage (COORD_WIDTH+1 stages). The whole pipeline
// advances while the output register is empty or being taken, so a stalled output holds
// every stage and drops nothing. Each coordinate takes the floor of the square root and one
// round-to-nearest (halves away from zero), saturated to the coordinate range; contained and
// disjoint pairs report zero points.
module circle_pair_intersection #(
    parameter int COORD_WIDTH = cpi_pkg::COORD_WIDTH_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    cpi_pair_if.sink      i_pair,
    cpi_res_if.source     o_res
);
    import cpi_pkg::*;

    localparam int W   = COORD_WIDTH;
    localparam int WE  = W + 1;           // centre differences and their magnitudes
    localparam int WD  = 2 * W + 2;       // squared distance, |L|
    localparam int WS  = 2 * W;           // radius sum/difference squares, K factors
    localparam int WK  = 4 * W;           // K
    localparam int WRT = 2 * W;           // floor(sqrt(K))
    localparam int WN  = 3 * W + 5;       // numerators
    localparam int QW  = W + 1;           // quotient magnitude
    localparam int WQ  = W + 2;           // signed offset and sum
    localparam int M1  = (WE + DIG_W - 1) / DIG_W;
    localparam int MK  = (WS + DIG_W - 1) / DIG_W;
    localparam int SQ  = WRT;

    localparam logic signed [WQ-1:0] SAT_HI = {{(WQ-W+1){1'b0}}, {(W-1){1'b1}}};
    localparam logic signed [WQ-1:0] SAT_LO = ~SAT_HI;

    typedef struct packed {
        logic                v;
        logic signed [W-1:0] fx;
        logic signed [W-1:0] fy;
        logic [WE-1:0]       adx;
        logic [WE-1:0]       ady;
        logic                ndx;
        logic                ndy;
        logic                negu;
    } t_side1;

    typedef struct packed {
        t_relation     rel;
        logic          lneg;
        logic [WD-1:0] lmag;
        logic [WD-1:0] d2;
    } t_side2;

    typedef struct packed {
        logic                v;
        t_relation           rel;
        logic                lneg;
        logic                ndx;
        logic                ndy;
        logic                negu;
        logic signed [W-1:0] fx;
        logic signed [W-1:0] fy;
        logic [WD-1:0]       d2;
    } t_mid;

    typedef struct packed {
        logic                v;
        t_relation           rel;
        logic signed [W-1:0] fx;
        logic signed [W-1:0] fy;
        logic [3:0]          neg;
    } t_tail;

    logic en;

    // Global advance: hold everything while the output beat waits
    logic r_vout;
    assign en           = !r_vout || o_res.ready;
    assign i_pair.ready = en;

    // ---------------- S1: differences, magnitudes, radius sum and difference
    logic signed [WE-1:0] n_dx, n_dy;
    logic [WE-1:0]        n_adx, n_ady;
    logic                 n_dx_pos, n_dy_pos;

    assign n_dx     = WE'(i_pair.other_x) - WE'(i_pair.first_x);
    assign n_dy     = WE'(i_pair.other_y) - WE'(i_pair.first_y);
    assign n_adx    = n_dx[WE-1] ? WE'(-n_dx) : WE'(n_dx);
    assign n_ady    = n_dy[WE-1] ? WE'(-n_dy) : WE'(n_dy);
    assign n_dx_pos = !n_dx[WE-1] && (n_dx != '0);
    assign n_dy_pos = !n_dy[WE-1] && (n_dy != '0);

    t_side1        r_s1;
    logic [W-1:0]  r_s1_sr;
    logic [W-2:0]  r_s1_mr;
    logic [W-2:0]  r_s1_r0, r_s1_r1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1.v <= 1'b0;
        end else if (en) begin
            r_s1.v <= i_pair.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s1.fx   <= i_pair.first_x;
            r_s1.fy   <= i_pair.first_y;
            r_s1.adx  <= n_adx;
            r_s1.ady  <= n_ady;
            r_s1.ndx  <= n_dx[WE-1];
            r_s1.ndy  <= n_dy[WE-1];
            r_s1.negu <= (n_dx_pos && n_dy[WE-1]) || (n_dx[WE-1] && n_dy_pos);
            r_s1_sr   <= {1'b0, i_pair.first_radius} + {1'b0, i_pair.other_radius};
            r_s1_mr   <= (i_pair.first_radius >= i_pair.other_radius)
                       ? (i_pair.first_radius - i_pair.other_radius)
                       : (i_pair.other_radius - i_pair.first_radius);
            r_s1_r0   <= i_pair.first_radius;
            r_s1_r1   <= i_pair.other_radius;
        end
    end

    // ---------------- Squares
    logic [2*WE-1:0] adx2, ady2, s2, m2, a2, b2;

    cpi_mul #(.WA(WE), .WB(WE)) u_mul_dx (
        .i_clk(i_clk), .i_en(en), .i_a(r_s1.adx), .i_b(r_s1.adx), .o_p(adx2));
    cpi_mul #(.WA(WE), .WB(WE)) u_mul_dy (
        .i_clk(i_clk), .i_en(en), .i_a(r_s1.ady), .i_b(r_s1.ady), .o_p(ady2));
    cpi_mul #(.WA(WE), .WB(WE)) u_mul_sr (
        .i_clk(i_clk), .i_en(en), .i_a(WE'(r_s1_sr)), .i_b(WE'(r_s1_sr)), .o_p(s2));
    cpi_mul #(.WA(WE), .WB(WE)) u_mul_mr (
        .i_clk(i_clk), .i_en(en), .i_a(WE'(r_s1_mr)), .i_b(WE'(r_s1_mr)), .o_p(m2));
    cpi_mul #(.WA(WE), .WB(WE)) u_mul_r0 (
        .i_clk(i_clk), .i_en(en), .i_a(WE'(r_s1_r0)), .i_b(WE'(r_s1_r0)), .o_p(a2));
    cpi_mul #(.WA(WE), .WB(WE)) u_mul_r1 (
        .i_clk(i_clk), .i_en(en), .i_a(WE'(r_s1_r1)), .i_b(WE'(r_s1_r1)), .o_p(b2));

    // ---------------- C1: squared distance and radius square difference
    logic [WD-1:0]        r_c1_d2, r_c1_s2, r_c1_m2;
    logic signed [WD:0]   r_c1_ab;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_c1_d2 <= WD'(adx2 + ady2);
            r_c1_s2 <= WD'(s2);
            r_c1_m2 <= WD'(m2);
            r_c1_ab <= $signed({1'b0, WD'(a2)}) - $signed({1'b0, WD'(b2)});
        end
    end

    // ---------------- C2: classify, L, discriminant factors
    t_relation          n_rel;
    t_relation          r_c2_rel;
    logic signed [WD:0] r_c2_l;
    logic [WD-1:0]      r_c2_d2;
    logic [WS-1:0]      r_c2_e1, r_c2_e2;

    always_comb begin
        if ((r_c1_d2 == '0) || (r_c1_d2 < r_c1_m2)) begin
            n_rel = REL_CONTAINED;
        end else if (r_c1_d2 > r_c1_s2) begin
            n_rel = REL_DISJOINT;
        end else begin
            n_rel = REL_TWO;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_c2_rel <= n_rel;
            r_c2_l   <= $signed({1'b0, r_c1_d2}) + r_c1_ab;
            r_c2_d2  <= r_c1_d2;
            r_c2_e1  <= (n_rel == REL_TWO) ? WS'(r_c1_s2 - r_c1_d2) : '0;
            r_c2_e2  <= (n_rel == REL_TWO) ? WS'(r_c1_d2 - r_c1_m2) : '0;
        end
    end

    // ---------------- C3: magnitude of L
    t_side2 r_c3;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_c3.rel  <= r_c2_rel;
            r_c3.lneg <= r_c2_l[WD];
            r_c3.lmag <= r_c2_l[WD] ? WD'(-r_c2_l) : WD'(r_c2_l);
            r_c3.d2   <= r_c2_d2;
        end
    end

    // ---------------- K and its square root
    logic [WK-1:0]  k_val;
    logic [WRT-1:0] rt;

    cpi_mul #(.WA(WS), .WB(WS)) u_mul_k (
        .i_clk(i_clk), .i_en(en), .i_a(r_c2_e1), .i_b(r_c2_e2), .o_p(k_val));

    cpi_sqrt #(.WI(WK)) u_sqrt (
        .i_clk(i_clk), .i_en(en), .i_x(k_val), .o_root(rt));

    // Side data waits for the root
    logic [$bits(t_side1)-1:0] side1_q;
    logic [$bits(t_side2)-1:0] side2_q;
    t_side1                    side1_d;
    t_side2                    side2_d;

    cpi_dly #(.WD($bits(t_side1)), .DEPTH(M1 + 2 + MK + SQ)) u_dly_s1 (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(en), .i_d(r_s1), .o_q(side1_q));
    cpi_dly #(.WD($bits(t_side2)), .DEPTH(MK + SQ - 1)) u_dly_s2 (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(en), .i_d(r_c3), .o_q(side2_q));

    assign side1_d = t_side1'(side1_q);
    assign side2_d = t_side2'(side2_q);

    // ---------------- Numerator products
    logic [WE+WD-1:0]  t1_p, v_p;
    logic [WE+WRT-1:0] u_p, w_p;

    cpi_mul #(.WA(WE), .WB(WD)) u_mul_t1 (
        .i_clk(i_clk), .i_en(en), .i_a(side1_d.adx), .i_b(side2_d.lmag), .o_p(t1_p));
    cpi_mul #(.WA(WE), .WB(WD)) u_mul_v (
        .i_clk(i_clk), .i_en(en), .i_a(side1_d.ady), .i_b(side2_d.lmag), .o_p(v_p));
    cpi_mul #(.WA(WE), .WB(WRT)) u_mul_u (
        .i_clk(i_clk), .i_en(en), .i_a(side1_d.ady), .i_b(rt), .o_p(u_p));
    cpi_mul #(.WA(WE), .WB(WRT)) u_mul_w (
        .i_clk(i_clk), .i_en(en), .i_a(side1_d.adx), .i_b(rt), .o_p(w_p));

    t_mid                 mid_d;
    logic [$bits(t_mid)-1:0] mid_q;
    t_mid                 mid_in;

    assign mid_d = '{v: side1_d.v, rel: side2_d.rel, lneg: side2_d.lneg,
                     ndx: side1_d.ndx, ndy: side1_d.ndy, negu: side1_d.negu,
                     fx: side1_d.fx, fy: side1_d.fy, d2: side2_d.d2};

    cpi_dly #(.WD($bits(t_mid)), .DEPTH(M1)) u_dly_mid (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(en), .i_d(mid_d), .o_q(mid_q));

    assign mid_in = t_mid'(mid_q);

    // ---------------- G1: apply signs to the products
    t_mid          r_g1, r_g2, r_g3, r_g4;
    logic [WN-1:0] r_g1_t1, r_g1_u, r_g1_v, r_g1_w;
    logic [WN-1:0] r_g2_n [4];
    logic [WN-1:0] r_g3_m [4];
    logic [3:0]    r_g3_neg, r_g4_neg;
    logic [WN-1:0] r_g4_n [4];
    logic [WD:0]   r_g4_den;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_g1.v <= 1'b0;
            r_g2.v <= 1'b0;
            r_g3.v <= 1'b0;
            r_g4.v <= 1'b0;
        end else if (en) begin
            r_g1.v <= mid_in.v;
            r_g2.v <= r_g1.v;
            r_g3.v <= r_g2.v;
            r_g4.v <= r_g3.v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            {r_g1.rel, r_g1.lneg, r_g1.ndx, r_g1.ndy, r_g1.negu, r_g1.fx, r_g1.fy, r_g1.d2}
                <= {mid_in.rel, mid_in.lneg, mid_in.ndx, mid_in.ndy, mid_in.negu,
                    mid_in.fx, mid_in.fy, mid_in.d2};
            r_g1_t1 <= (mid_in.ndx ^ mid_in.lneg) ? WN'(-WN'(t1_p)) : WN'(t1_p);
            r_g1_v  <= (mid_in.ndy ^ mid_in.lneg) ? WN'(-WN'(v_p)) : WN'(v_p);
            r_g1_u  <= mid_in.negu ? WN'(-WN'(u_p)) : WN'(u_p);
            r_g1_w  <= WN'(w_p);
        end
    end

    // ---------------- G2: four signed numerators
    always_ff @(posedge i_clk) begin
        if (en) begin
            {r_g2.rel, r_g2.lneg, r_g2.ndx, r_g2.ndy, r_g2.negu, r_g2.fx, r_g2.fy, r_g2.d2}
                <= {r_g1.rel, r_g1.lneg, r_g1.ndx, r_g1.ndy, r_g1.negu,
                    r_g1.fx, r_g1.fy, r_g1.d2};
            r_g2_n[0] <= r_g1_t1 + r_g1_u;
            r_g2_n[1] <= r_g1_v - r_g1_w;
            r_g2_n[2] <= r_g1_t1 - r_g1_u;
            r_g2_n[3] <= r_g1_v + r_g1_w;
        end
    end

    // ---------------- G3: magnitudes and signs
    always_ff @(posedge i_clk) begin
        if (en) begin
            {r_g3.rel, r_g3.lneg, r_g3.ndx, r_g3.ndy, r_g3.negu, r_g3.fx, r_g3.fy, r_g3.d2}
                <= {r_g2.rel, r_g2.lneg, r_g2.ndx, r_g2.ndy, r_g2.negu,
                    r_g2.fx, r_g2.fy, r_g2.d2};
            for (int i = 0; i < 4; i++) begin
                r_g3_neg[i] <= r_g2_n[i][WN-1];
                r_g3_m[i]   <= r_g2_n[i][WN-1] ? (-r_g2_n[i]) : r_g2_n[i];
            end
        end
    end

    // ---------------- G4: add half the divisor for rounding
    always_ff @(posedge i_clk) begin
        if (en) begin
            {r_g4.rel, r_g4.lneg, r_g4.ndx, r_g4.ndy, r_g4.negu, r_g4.fx, r_g4.fy, r_g4.d2}
                <= {r_g3.rel, r_g3.lneg, r_g3.ndx, r_g3.ndy, r_g3.negu,
                    r_g3.fx, r_g3.fy, r_g3.d2};
            r_g4_neg <= r_g3_neg;
            r_g4_den <= {r_g3.d2, 1'b0};
            for (int i = 0; i < 4; i++) begin
                r_g4_n[i] <= r_g3_m[i] + WN'(r_g3.d2);
            end
        end
    end

    // ---------------- Dividers
    logic [QW-1:0] quo [4];

    for (genvar i = 0; i < 4; i++) begin : g_div
        cpi_div #(.WN(WN), .WDV(WD + 1), .QW(QW)) u_div (
            .i_clk(i_clk), .i_en(en), .i_num(r_g4_n[i]), .i_den(r_g4_den), .o_quo(quo[i]));
    end

    t_tail                    tail_d, tail_in;
    logic [$bits(t_tail)-1:0] tail_q;

    assign tail_d = '{v: r_g4.v, rel: r_g4.rel, fx: r_g4.fx, fy: r_g4.fy, neg: r_g4_neg};

    cpi_dly #(.WD($bits(t_tail)), .DEPTH(QW)) u_dly_tail (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(en), .i_d(tail_d), .o_q(tail_q));

    assign tail_in = t_tail'(tail_q);

    // ---------------- H1: signed offsets
    t_tail                r_h1;
    logic signed [WQ-1:0] r_h1_q [4];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_h1.v <= 1'b0;
        end else if (en) begin
            r_h1.v <= tail_in.v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_h1.rel <= tail_in.rel;
            r_h1.fx  <= tail_in.fx;
            r_h1.fy  <= tail_in.fy;
            r_h1.neg <= tail_in.neg;
            for (int i = 0; i < 4; i++) begin
                r_h1_q[i] <= tail_in.neg[i] ? WQ'(-WQ'(quo[i])) : WQ'(quo[i]);
            end
        end
    end

    // ---------------- H2: add centres, saturate, output register
    logic signed [WQ-1:0] n_sum [4];
    logic signed [W-1:0]  n_pt  [4];
    t_relation            r_rel;
    logic signed [W-1:0]  r_pt  [4];

    always_comb begin
        n_sum[0] = WQ'(r_h1.fx) + r_h1_q[0];
        n_sum[1] = WQ'(r_h1.fy) + r_h1_q[1];
        n_sum[2] = WQ'(r_h1.fx) + r_h1_q[2];
        n_sum[3] = WQ'(r_h1.fy) + r_h1_q[3];
        for (int i = 0; i < 4; i++) begin
            if (r_h1.rel != REL_TWO) begin
                n_pt[i] = '0;
            end else if (n_sum[i] > SAT_HI) begin
                n_pt[i] = W'(SAT_HI);
            end else if (n_sum[i] < SAT_LO) begin
                n_pt[i] = W'(SAT_LO);
            end else begin
                n_pt[i] = W'(n_sum[i]);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vout <= 1'b0;
        end else if (en) begin
            r_vout <= r_h1.v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_rel <= r_h1.rel;
            for (int i = 0; i < 4; i++) begin
                r_pt[i] <= n_pt[i];
            end
        end
    end

    assign o_res.valid    = r_vout;
    assign o_res.relation = r_rel;
    assign o_res.point0_x = r_pt[0];
    assign o_res.point0_y = r_pt[1];
    assign o_res.point1_x = r_pt[2];
    assign o_res.point1_y = r_pt[3];
endmodule

FILE: rtl/cpi_chk.sv
// Port-level checks for the circle pair intersection block, bound to the top level.
module cpi_chk #(
    parameter int W = cpi_pkg::COORD_WIDTH_DEF
) (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                i_in_ready,
    input logic                i_out_valid,
    input logic                i_out_ready,
    input cpi_pkg::t_relation  i_relation,
    input logic signed [W-1:0] i_p0x,
    input logic signed [W-1:0] i_p0y,
    input logic signed [W-1:0] i_p1x,
    input logic signed [W-1:0] i_p1y
);
    import cpi_pkg::*;

    // Hold a stalled result beat
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_relation)
            && $stable(i_p0x) && $stable(i_p0y) && $stable(i_p1x) && $stable(i_p1y))
        else $error("result beat changed while stalled");

    // Keep result valid low right after reset
    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result valid right after reset");

    // Stall the input while the output beat is held
    a_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |-> !i_in_ready)
        else $error("pair taken while output stalled");

    // Report zero points for contained or disjoint pairs
    a_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && (i_relation != REL_TWO) |->
            (i_p0x == '0) && (i_p0y == '0) && (i_p1x == '0) && (i_p1y == '0))
        else $error("nonzero points on a non-crossing pair");

    // Accept pairs freely while the output register is empty
    a_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_out_valid |-> i_in_ready)
        else $error("input not ready with empty output");
endmodule

bind circle_pair_intersection cpi_chk #(.W(COORD_WIDTH)) u_cpi_chk (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_in_ready (i_pair.ready),
    .i_out_valid(o_res.valid),
    .i_out_ready(o_res.ready),
    .i_relation (o_res.relation),
    .i_p0x      (o_res.point0_x),
    .i_p0y      (o_res.point0_y),
    .i_p1x      (o_res.point1_x),
    .i_p1y      (o_res.point1_y)
);

FILE: verif/cpi_checker.sv
// Checker for the circle pair intersection block: predicts each result and compares it.
`timescale 1ns / 1ps

module cpi_checker (
    input  logic  i_clk,
    input  logic  i_rst_n,
    cpi_pair_if   i_pair,
    cpi_res_if    i_res,
    output int    o_errors,
    output int    o_pending,
    output int    o_results,
    output int    o_crossings
);
    import cpi_pkg::*;

    typedef logic signed [255:0] t_wide;

    typedef struct {
        t_relation          relation;
        logic signed [31:0] p0x;
        logic signed [31:0] p0y;
        logic signed [31:0] p1x;
        logic signed [31:0] p1y;
    } t_crossing;

    t_crossing crossings_due[$];
    int        mismatch_cnt;
    int        result_cnt;
    int        crossing_cnt;
    int        pending_cnt;

    // Floor square root, bit by bit from the top
    function automatic t_wide floor_root(input t_wide k);
        t_wide r;
        t_wide c;
        r = '0;
        for (int i = 80; i >= 0; i--) begin
            c = r | (t_wide'(1) <<< i);
            if (c * c <= k) r = c;
        end
        return r;
    endfunction

    // Divide by 2*h, rounding to nearest with halves away from zero
    function automatic t_wide half_round_div(input t_wide n, input t_wide h);
        if (n < 0) return -((-n + h) / (2 * h));
        return (n + h) / (2 * h);
    endfunction

    // Offset a centre coordinate and saturate to the coordinate range
    function automatic logic signed [31:0] offset_coord(input t_wide centre, input t_wide num,
                                                        input t_wide d2);
        t_wide v;
        v = centre + half_round_div(num, d2);
        if (v < -(t_wide'(1) <<< 31)) v = -(t_wide'(1) <<< 31);
        if (v > (t_wide'(1) <<< 31) - 1) v = (t_wide'(1) <<< 31) - 1;
        return v[31:0];
    endfunction

    // Classify the pair and solve the crossing points
    function automatic t_crossing solve_pair(input logic signed [31:0] fx,
                                             input logic signed [31:0] fy,
                                             input logic [30:0]        fr,
                                             input logic signed [31:0] ox,
                                             input logic signed [31:0] oy,
                                             input logic [30:0]        orad);
        t_crossing ans;
        t_wide cx, cy, r0, r1, dx, dy, d2, m2, s2, k, rt, l, sdy, adx, t1, u, v, w;
        cx = fx;
        cy = fy;
        dx = ox;
        dy = oy;
        dx = dx - cx;
        dy = dy - cy;
        r0 = {225'b0, fr};
        r1 = {225'b0, orad};
        d2 = dx * dx + dy * dy;
        m2 = (r0 - r1) * (r0 - r1);
        s2 = (r0 + r1) * (r0 + r1);
        ans = '{REL_TWO, 0, 0, 0, 0};
        if (d2 == 0 || d2 < m2) begin
            ans.relation = REL_CONTAINED;
            return ans;
        end
        if (d2 > s2) begin
            ans.relation = REL_DISJOINT;
            return ans;
        end
        k = (s2 - d2) * (d2 - m2);
        if (k < 0) k = 0;
        rt = floor_root(k);
        l = d2 + r0 * r0 - r1 * r1;
        if (dx > 0) sdy = dy;
        else if (dx < 0) sdy = -dy;
        else sdy = (dy < 0) ? -dy : dy;
        adx = (dx < 0) ? -dx : dx;
        t1 = l * dx;
        u = rt * sdy;
        v = l * dy;
        w = rt * adx;
        ans.p0x = offset_coord(cx, t1 + u, d2);
        ans.p0y = offset_coord(cy, v - w, d2);
        ans.p1x = offset_coord(cx, t1 - u, d2);
        ans.p1y = offset_coord(cy, v + w, d2);
        return ans;
    endfunction

    // Track pair beats and check result beats
    always @(posedge i_clk) begin
        t_crossing want;
        t_crossing got;
        if (i_rst_n) begin
            if (i_pair.valid && i_pair.ready) begin
                want = solve_pair(i_pair.first_x, i_pair.first_y, i_pair.first_radius,
                                  i_pair.other_x, i_pair.other_y, i_pair.other_radius);
                if (want.relation == REL_TWO) crossing_cnt++;
                crossings_due = {crossings_due, want};
            end
            if (i_res.valid && i_res.ready) begin
                result_cnt++;
                got = '{i_res.relation, i_res.point0_x, i_res.point0_y,
                        i_res.point1_x, i_res.point1_y};
                if (crossings_due.size() == 0) begin
                    mismatch_cnt++;
                    if (mismatch_cnt <= 10)
                        $display("ERROR: unexpected result beat rel=%0d", got.relation);
                end else begin
                    want = crossings_due.pop_front();
                    if (got.relation !== want.relation || got.p0x !== want.p0x ||
                        got.p0y !== want.p0y || got.p1x !== want.p1x ||
                        got.p1y !== want.p1y) begin
                        mismatch_cnt++;
                        if (mismatch_cnt <= 10)
                            $display({"ERROR: result %0d exp rel=%0d p0=(%0d,%0d) ",
                                      "p1=(%0d,%0d) got rel=%0d p0=(%0d,%0d) p1=(%0d,%0d)"},
                                     result_cnt, want.relation, want.p0x, want.p0y,
                                     want.p1x, want.p1y, got.relation, got.p0x, got.p0y,
                                     got.p1x, got.p1y);
                    end
                end
            end
            pending_cnt = crossings_due.size();
        end
    end

    assign o_errors    = mismatch_cnt;
    assign o_pending   = pending_cnt;
    assign o_results   = result_cnt;
    assign o_crossings = crossing_cnt;

    initial begin
        mismatch_cnt = 0;
        result_cnt   = 0;
        crossing_cnt = 0;
        pending_cnt  = 0;
    end
endmodule

FILE: verif/tb_circle_pair_intersection.sv
// Testbench top for the circle pair intersection block: stimulus, handshake idling and verdict.
`timescale 1ns / 1ps

module tb_circle_pair_intersection;
    import cpi_pkg::*;

    localparam int PHASE_ITEMS = 475;
    localparam int STALL_LIMIT = 20000;
    localparam int DRAIN_CYCLES = 150;

    logic i_clk;
    logic i_rst_n;
    int   errors, pending, results, crossings;
    int   idle_pct, stall_pct, pairs_sent;
    int   quiet_cycles = 0;

    cpi_pair_if pair_ch ();
    cpi_res_if  res_ch ();

    circle_pair_intersection dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_pair  (pair_ch.sink),
        .o_res   (res_ch.source)
    );

    cpi_checker checker_inst (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_pair      (pair_ch),
        .i_res       (res_ch),
        .o_errors    (errors),
        .o_pending   (pending),
        .o_results   (results),
        .o_crossings (crossings)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // Randomize result ready at the falling edge
    always @(negedge i_clk) begin
        res_ch.ready <= ($urandom_range(99) >= stall_pct);
    end

    // Drive one pair beat and hold it until accepted
    task automatic send_pair(input logic signed [31:0] fx, input logic signed [31:0] fy,
                             input logic [31:0] fr, input logic signed [31:0] ox,
                             input logic signed [31:0] oy, input logic [31:0] orad);
        @(negedge i_clk);
        while ($urandom_range(99) < idle_pct) begin
            pair_ch.valid = 1'b0;
            @(negedge i_clk);
        end
        pair_ch.valid        = 1'b1;
        pair_ch.first_x      = fx;
        pair_ch.first_y      = fy;
        pair_ch.first_radius = fr[30:0];
        pair_ch.other_x      = ox;
        pair_ch.other_y      = oy;
        pair_ch.other_radius = orad[30:0];
        do @(posedge i_clk); while (!pair_ch.ready);
        pairs_sent++;
    endtask

    // Radius from a real value, clamped to the radius range
    function automatic logic [31:0] to_radius(input real r);
        if (r >= 2147483647.0) return 32'h7FFF_FFFF;
        if (r <= 0.0) return '0;
        return 32'($rtoi(r));
    endfunction

    // Random pair: mostly crossing circles, some vertical, some contained, some noise
    task automatic send_random_pair();
        logic signed [31:0] fx, fy, ox, oy;
        logic [31:0] fr, orad;
        real span, r0, lo, hi;
        int kind;
        kind = $urandom_range(9);
        fx = $signed($urandom) >>> $urandom_range(1, 28);
        fy = $signed($urandom) >>> $urandom_range(1, 28);
        ox = $signed($urandom) >>> $urandom_range(1, 28);
        oy = $signed($urandom) >>> $urandom_range(1, 28);
        if (kind == 8) ox = fx;
        if (kind <= 1) begin
            send_pair($urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
        end else if (kind == 9) begin
            fr = $urandom_range(32'h7FFFFFFF);
            send_pair(fx, fy, fr, fx + $signed(32'($urandom_range(255)) - 128), fy,
                      $urandom_range(255));
        end else begin
            span = $sqrt((real'(ox) - real'(fx)) ** 2 + (real'(oy) - real'(fy)) ** 2);
            r0 = span * $urandom_range(5, 150) / 100.0;
            lo = (span > r0) ? span - r0 : r0 - span;
            hi = span + r0;
            fr = to_radius(r0);
            orad = to_radius(lo + (hi - lo) * $urandom_range(1000) / 1000.0);
            send_pair(fx, fy, fr, ox, oy, orad);
        end
    endtask

    // Count cycles with no beat on either channel
    always @(posedge i_clk) begin
        if ((pair_ch.valid && pair_ch.ready) || (res_ch.valid && res_ch.ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("ERROR: no beat for %0d cycles, %0d results pending", STALL_LIMIT, pending);
            $display("*** FAILED ***");
            $finish;
        end
    end

    localparam logic signed [31:0] ONE = 32'sh1000_0000;
    localparam logic signed [31:0] CMAX = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] CMIN = 32'sh8000_0000;
    localparam logic [31:0] RMAX = 32'h7FFF_FFFF;

    initial begin
        pair_ch.valid        = 1'b0;
        pair_ch.first_x      = '0;
        pair_ch.first_y      = '0;
        pair_ch.first_radius = '0;
        pair_ch.other_x      = '0;
        pair_ch.other_y      = '0;
        pair_ch.other_radius = '0;
        idle_pct             = 0;
        stall_pct            = 0;
        pairs_sent           = 0;
        i_rst_n              = 1'b0;
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed: coincident, tangent, aligned, extremes and saturation
        send_pair(0, 0, 0, 0, 0, 0);
        send_pair(ONE, ONE, ONE, ONE, ONE, ONE);
        send_pair(0, 0, ONE, ONE, 0, ONE);
        send_pair(0, 0, ONE, 3 * ONE, 0, 2 * ONE);
        send_pair(0, 0, 3 * ONE, ONE, 0, 2 * ONE);
        send_pair(0, 0, ONE, 0, ONE, ONE);
        send_pair(0, 0, ONE, 0, -ONE, ONE);
        send_pair(0, 0, ONE, -ONE, 0, ONE);
        send_pair(0, 0, ONE, ONE, ONE, ONE);
        send_pair(0, 0, ONE, -ONE, -ONE, ONE);
        send_pair(0, 0, ONE, 5 * ONE, 0, ONE);
        send_pair(0, 0, 4 * ONE, 0, ONE, ONE);
        send_pair(CMAX, CMAX, RMAX, CMIN, CMIN, RMAX);
        send_pair(CMIN, CMIN, RMAX, CMAX, CMIN, RMAX);
        send_pair(CMAX, 0, RMAX, CMAX, 32'sh4000_0000, RMAX);
        send_pair(CMIN, 0, RMAX, CMIN, -32'sh4000_0000, RMAX);
        send_pair(0, CMAX, RMAX, 32'sh4000_0000, CMAX, RMAX);
        send_pair(0, 0, 1, 1, 0, 1);
        send_pair(0, 0, RMAX, 0, 1, RMAX);
        send_pair(-1, -1, 0, 0, 0, 1);
        send_pair(CMAX, CMIN, 0, CMAX, CMIN, RMAX);

        // Random phases with different idling on each side
        for (int ph = 0; ph < 4; ph++) begin
            case (ph)
                0: begin idle_pct = 0;  stall_pct = 0;  end
                1: begin idle_pct = 73; stall_pct = 0;  end
                2: begin idle_pct = 0;  stall_pct = 73; end
                default: begin idle_pct = 30; stall_pct = 30; end
            endcase
            for (int n = 0; n < PHASE_ITEMS; n++) send_random_pair();
        end
        @(negedge i_clk);
        pair_ch.valid = 1'b0;
        stall_pct = 0;

        // Drain the pipeline
        while (pending != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Sent %0d disk pairs, %0d results checked, %0d with two crossing points.",
                 pairs_sent, results, crossings);
        $display("Idling phases: none, sender 73%%, receiver 73%%, both 30%%; %0d mismatches.",
                 errors);
        if (errors == 0 && pending == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end
endmodule
